/* rtl/core/scanline_triangle_fill_top_defines.svh */
// Assertion helpers used by the checker file.
`ifndef SCANLINE_TRIANGLE_FILL_TOP_DEFINES_SVH
`define SCANLINE_TRIANGLE_FILL_TOP_DEFINES_SVH

// Checked only while out of reset.
`define STF_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define STF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/stf_pkg.sv */
`default_nettype none

package stf_pkg;

  localparam int LINE_WIDTH    = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int COL_W         = $clog2(LINE_WIDTH);

  localparam int IN_DATA_W  = 112;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;

  localparam int COORD_W = 12;
  localparam int DIFF_W  = 14;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int EDGE_W  = 26;
  localparam int CNT_W   = 9;
  localparam int PIX_W   = 16;

  localparam logic [2:0] MUL_STEPS = 3'd6;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_DRAW  = 2'd1,
    KIND_READ  = 2'd2
  } stf_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOX,
    ST_CLEAR,
    ST_SETUP,
    ST_WALK,
    ST_DONE
  } stf_state_e;

  typedef struct packed {
    logic       load;
    logic       box;
    logic       clear;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       walk;
    logic       res_load;
  } stf_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       draw_ok;
    logic       last;
    logic       out_free;
  } stf_sts_t;

endpackage

`default_nettype wire

/* rtl/core/stf_ctrl.sv */
`default_nettype none

module stf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  stf_pkg::stf_sts_t sts_i,
  output stf_pkg::stf_cmd_t cmd_o
);
  import stf_pkg::*;

  stf_state_e state_q, state_d;
  logic [2:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) state_d = ST_BOX;
      end
      ST_BOX: begin
        unique case (sts_i.kind)
          KIND_CLEAR: state_d = ST_CLEAR;
          KIND_DRAW:  state_d = sts_i.draw_ok ? ST_SETUP : ST_DONE;
          default:    state_d = ST_DONE;
        endcase
      end
      ST_CLEAR: begin
        if (sts_i.last) state_d = ST_DONE;
      end
      ST_SETUP: begin
        step_d = step_q + 3'd1;
        if (step_q == MUL_STEPS) begin
          state_d = ST_WALK;
          step_d  = '0;
        end
      end
      ST_WALK: begin
        if (sts_i.last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    s_tready_o     = 1'b0;
    cmd_o.mul_sel  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        cmd_o.load = s_tvalid_i;
      end
      ST_BOX:   cmd_o.box = 1'b1;
      ST_CLEAR: cmd_o.clear = 1'b1;
      ST_SETUP: cmd_o.mul_en = (step_q < MUL_STEPS);
      ST_WALK:  cmd_o.walk = 1'b1;
      ST_DONE:  cmd_o.res_load = sts_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/stf_datapath.sv */
`default_nettype none

module stf_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [stf_pkg::IN_DATA_W-1:0]      s_tdata_i,
  input  logic [stf_pkg::IN_USER_W-1:0]      s_tuser_i,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  output logic [stf_pkg::OUT_DATA_W-1:0]     m_tdata_o,
  input  logic                               cfg_we_i,
  input  logic [stf_pkg::PIX_W-1:0]          cfg_wdata_i,
  input  stf_pkg::stf_cmd_t                  cmd_i,
  output stf_pkg::stf_sts_t                  sts_o
);
  import stf_pkg::*;

  localparam logic signed [COORD_W:0] XMAX_S = (COORD_W + 1)'(LINE_WIDTH - 1);

  function automatic logic signed [COORD_W-1:0] min3(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b,
                                                      input logic signed [COORD_W-1:0] c);
    logic signed [COORD_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [COORD_W-1:0] max3(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b,
                                                      input logic signed [COORD_W-1:0] c);
    logic signed [COORD_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // item registers
  logic [1:0]                 kind_q;
  logic [7:0]                 row_q;
  logic [8:0]                 col_q;
  logic signed [COORD_W-1:0]  ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic [PIX_W-1:0]           fill_q;
  logic [PIX_W-1:0]           bg_q;

  logic [COL_W-1:0]           x_q, xe_q;
  logic [CNT_W-1:0]           cnt_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic [2:0]                 psel_q;
  logic                       pv_q;
  logic signed [EDGE_W-1:0]   w_q [3];
  logic [PIX_W-1:0]           rd_q;
  logic [PIX_W-1:0]           line_mem [LINE_WIDTH];
  logic                       out_vld_q;
  logic [PIX_W-1:0]           out_pix_q;
  logic [CNT_W-1:0]           out_cnt_q;

  // bounding box
  logic signed [COORD_W-1:0]  minx, maxx, miny, maxy;
  logic signed [COORD_W:0]    xs, xe, row_s;
  logic                       row_ok, draw_ok, col_ok, last;

  always_comb begin
    minx    = min3(ax_q, bx_q, cx_q);
    maxx    = max3(ax_q, bx_q, cx_q);
    miny    = min3(ay_q, by_q, cy_q);
    maxy    = max3(ay_q, by_q, cy_q);
    row_s   = {5'b0, row_q};
    xs      = minx[COORD_W-1] ? '0 : {minx[COORD_W-1], minx};
    xe      = ($signed({maxx[COORD_W-1], maxx}) > XMAX_S) ? XMAX_S :
              $signed({maxx[COORD_W-1], maxx});
    row_ok  = (row_s >= $signed({miny[COORD_W-1], miny})) &&
              (row_s <= $signed({maxy[COORD_W-1], maxy})) &&
              (32'(row_q) < SCREEN_HEIGHT);
    draw_ok = row_ok && (xs <= xe);
    col_ok  = (32'(col_q) < LINE_WIDTH);
    last    = (x_q == xe_q);
  end

  // edge setup operands
  logic signed [DIFF_W-1:0] dxa, dxb, dxc, dya, dyb, dyc;
  logic signed [DIFF_W-1:0] opa, opb;

  always_comb begin
    dxa = {{2{ax_q[COORD_W-1]}}, ax_q} - {{(DIFF_W-COL_W){1'b0}}, x_q};
    dxb = {{2{bx_q[COORD_W-1]}}, bx_q} - {{(DIFF_W-COL_W){1'b0}}, x_q};
    dxc = {{2{cx_q[COORD_W-1]}}, cx_q} - {{(DIFF_W-COL_W){1'b0}}, x_q};
    dya = {{2{ay_q[COORD_W-1]}}, ay_q} - {6'b0, row_q};
    dyb = {{2{by_q[COORD_W-1]}}, by_q} - {6'b0, row_q};
    dyc = {{2{cy_q[COORD_W-1]}}, cy_q} - {6'b0, row_q};
    // e(P,Q) = (Px-x)(Qy-r) - (Py-r)(Qx-x); w1 = e(C,A), w2 = e(A,B), w3 = e(B,C)
    case (cmd_i.mul_sel)
      3'd0:    begin opa = dxc; opb = dya; end
      3'd1:    begin opa = dyc; opb = dxa; end
      3'd2:    begin opa = dxa; opb = dyb; end
      3'd3:    begin opa = dya; opb = dxb; end
      3'd4:    begin opa = dxb; opb = dyc; end
      3'd5:    begin opa = dyb; opb = dxc; end
      default: begin opa = '0;  opb = '0;  end
    endcase
  end

  // per-column steps
  logic signed [EDGE_W-1:0] dw [3];
  logic                     in_tri;

  always_comb begin
    dw[0]  = EDGE_W'(cy_q) - EDGE_W'(ay_q);
    dw[1]  = EDGE_W'(ay_q) - EDGE_W'(by_q);
    dw[2]  = EDGE_W'(by_q) - EDGE_W'(cy_q);
    in_tri = (!w_q[0][EDGE_W-1] && !w_q[1][EDGE_W-1] && !w_q[2][EDGE_W-1]) ||
             ((w_q[0][EDGE_W-1] || (w_q[0] == '0)) &&
              (w_q[1][EDGE_W-1] || (w_q[1] == '0)) &&
              (w_q[2][EDGE_W-1] || (w_q[2] == '0)));
  end

  logic             wr_en;
  logic [PIX_W-1:0] wr_data;
  logic             rd_en;

  assign wr_en   = cmd_i.clear || (cmd_i.walk && in_tri);
  assign wr_data = cmd_i.clear ? bg_q : fill_q;
  assign rd_en   = cmd_i.box && (kind_q == KIND_READ) && col_ok;

  always_ff @(posedge clk_i) begin
    if (wr_en) line_mem[x_q] <= wr_data;
    if (rd_en) rd_q <= line_mem[COL_W'(col_q)];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= s_tuser_i[1:0];
      row_q  <= s_tdata_i[7:0];
      col_q  <= s_tdata_i[16:8];
      ax_q   <= s_tdata_i[28:17];
      ay_q   <= s_tdata_i[40:29];
      bx_q   <= s_tdata_i[52:41];
      by_q   <= s_tdata_i[64:53];
      cx_q   <= s_tdata_i[76:65];
      cy_q   <= s_tdata_i[88:77];
      fill_q <= s_tdata_i[104:89];
    end

    if (cmd_i.box) begin
      cnt_q <= '0;
      if (kind_q == KIND_CLEAR) begin
        x_q  <= '0;
        xe_q <= COL_W'(LINE_WIDTH - 1);
      end else begin
        x_q  <= COL_W'(xs);
        xe_q <= COL_W'(xe);
      end
    end else if (cmd_i.clear || cmd_i.walk) begin
      if (!last) x_q <= x_q + COL_W'(1);
      if (cmd_i.walk && in_tri && (cnt_q != '1)) cnt_q <= cnt_q + CNT_W'(1);
    end

    prod_q <= opa * opb;
    psel_q <= cmd_i.mul_sel;
    pv_q   <= cmd_i.mul_en;

    if (pv_q) begin
      if (!psel_q[0]) w_q[psel_q[2:1]] <= EDGE_W'(prod_q);
      else            w_q[psel_q[2:1]] <= w_q[psel_q[2:1]] - EDGE_W'(prod_q);
    end else if (cmd_i.walk) begin
      for (int i = 0; i < 3; i++) w_q[i] <= w_q[i] + dw[i];
    end

    if (cmd_i.res_load) begin
      out_pix_q <= ((kind_q == KIND_READ) && col_ok) ? rd_q : '0;
      out_cnt_q <= (kind_q == KIND_DRAW) ? cnt_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) bg_q <= cfg_wdata_i;
      if (cmd_i.res_load)  out_vld_q <= 1'b1;
      else if (m_tready_i) out_vld_q <= 1'b0;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = {(OUT_DATA_W - CNT_W - PIX_W)'(0), out_cnt_q, out_pix_q};

  assign sts_o.kind     = kind_q;
  assign sts_o.draw_ok  = draw_ok;
  assign sts_o.last     = last;
  assign sts_o.out_free = !out_vld_q || m_tready_i;

endmodule

`default_nettype wire

/* rtl/core/scanline_triangle_fill_top.sv */
// Scan-line triangle fill. Holds one line of 16-bit pixels in a RAM with
// one write port and one read port, and takes one item at a time. A clear
// item writes the background color to every column, one per cycle. A draw
// item computes the bounding box, then the edge setup through a single
// shared multiplier, then walks the clipped box one column per cycle while
// the edge values step by adds; a draw whose row misses the box skips the
// setup and the walk. A read item reads one column from the RAM.
// The RAM write port sets the one-pixel-per-cycle pace. The result sits in an
// output register, so the next item can be taken while it waits.
`default_nettype none

module scanline_triangle_fill_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  // row[7:0], column[16:8], ax[28:17], ay[40:29], bx[52:41], by[64:53],
  // cx[76:65], cy[88:77], fill_color[104:89], zero above
  input  logic [stf_pkg::IN_DATA_W-1:0]  s_tdata_i,
  // kind[1:0]
  input  logic [stf_pkg::IN_USER_W-1:0]  s_tuser_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // pixel_color[15:0], pixels_written[24:16], zero above
  output logic [stf_pkg::OUT_DATA_W-1:0] m_tdata_o,
  input  logic                          cfg_we_i,
  input  logic [stf_pkg::PIX_W-1:0]      cfg_wdata_i
);
  import stf_pkg::*;

  stf_cmd_t cmd;
  stf_sts_t sts;

  stf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stf_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

/* rtl/core/stf_checker.sv */
`default_nettype none
`include "scanline_triangle_fill_top_defines.svh"

module stf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_tvalid_i,
  input logic                          s_tready_o,
  input logic                          m_tvalid_o,
  input logic                          m_tready_i,
  input logic [stf_pkg::OUT_DATA_W-1:0] m_tdata_o
);
  import stf_pkg::*;

  `STF_ASSERT_RST(a_out_hold, clk_i, rst_ni, m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o), "result changed while stalled")
  `STF_ASSERT_RST(a_busy_after_accept, clk_i, rst_ni, s_tvalid_i && s_tready_o |=> !s_tready_o, "item taken while busy")
  `STF_ASSERT_RST(a_one_field, clk_i, rst_ni, m_tvalid_o |-> (m_tdata_o[15:0] == '0) || (m_tdata_o[24:16] == '0), "pixel and count both set")
  `STF_ASSERT_RST(a_count_range, clk_i, rst_ni, m_tvalid_o |-> (32'(m_tdata_o[24:16]) <= LINE_WIDTH), "count beyond line width")
  `STF_ASSERT_ALWAYS(a_pad_zero, clk_i, m_tvalid_o |-> (m_tdata_o[OUT_DATA_W-1:25] == '0), "padding bits set")

endmodule

bind scanline_triangle_fill_top stf_checker u_stf_checker (.*);

`default_nettype wire
